// ===== src/dse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dse_pkg;

	localparam int DICT_ENTRIES  = 8192;
	localparam int DICT_AW       = $clog2(DICT_ENTRIES);
	localparam int MAX_EXPANSION = 260;
	localparam int BUF_DEPTH     = 264;
	localparam int BUF_AW        = $clog2(BUF_DEPTH);
	localparam int TOT_W         = 9;
	localparam int SYM_W         = 13;
	localparam int IDX_W         = 13;
	localparam int CODE_W        = 3;
	localparam int MAX_CODE      = 5;
	localparam int RESET_CODE    = 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_PUTP,
		ST_PUTC,
		ST_EMIT,
		ST_FLUSH,
		ST_PUSH,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic        last;
		logic        error;
	} out_word_t;

	// Byte i of a dictionary entry, byte zero in the top bits.
	function automatic logic [7:0] entry_byte(logic [63:0] e, logic [2:0] i);
		return e[8 * (7 - int'(i)) +: 8];
	endfunction

endpackage
`default_nettype wire

// ===== src/dictionary_symbol_expander_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Dictionary symbol expander. Kind-0 transactions (s_axis_tuser = 0) load one 8-byte
// dictionary entry and give no output. Kind-1 transactions expand
// a symbol, masked to cfg width (code + 8 bits, codes above 5 act as 5): a symbol up
// to 255 yields that byte; a larger one walks the predecessor chain through the
// dictionary, placing bytes into a 264-byte assembly buffer, and the result goes out
// as 8-byte words (first byte in the top bits, byte count and tlast alongside). A
// chain over 260 characters or with bad lengths gives one error word (tuser = 1).
// Sequence: the block is busy for one item at a time. A literal byte is written to
// the buffer on acceptance. A chain takes one registered dictionary read per entry,
// then writes psl bytes for each preceded entry and csl bytes for the final one.
// Each output word of n bytes is then read from the buffer byte by byte, flushed,
// and handed to the output register; the handoff waits while that register is full.
// The pace is set by the byte buffer, written and read one byte a cycle, and by
// the one registered dictionary read per chain step. The next item is
// accepted while the last word still waits in the output register.
module dictionary_symbol_expander_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [95:0] s_axis_tdata,  // entry_index[12:0], entry_data[76:13], symbol[89:77]
	input  wire logic        s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,  // out_bytes[63:0], byte_count[67:64]
	output logic             m_axis_tlast,  // last
	output logic             m_axis_tuser,  // data_error
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_wdata      // symbol_size_code
);
	import dse_pkg::*;

	logic [CODE_W-1:0] code_q;
	logic              core_valid;
	logic              core_ready;
	out_word_t         core_word;
	out_word_t         o_word;

	// Hold the symbol size code; the user must write it only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= CODE_W'(RESET_CODE);
		end else if (cfg_we) begin
			code_q <= cfg_wdata;
		end
	end

	dse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.kind        (s_axis_tuser),
		.entry_index (s_axis_tdata[12:0]),
		.entry_data  (s_axis_tdata[76:13]),
		.symbol      (s_axis_tdata[89:77]),
		.size_code   (code_q),
		.out_valid   (core_valid),
		.out_ready   (core_ready),
		.out_word    (core_word)
	);

	// Output register parts the sequencer from the downstream handshake.
	dse_ostage u_ostage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (core_valid),
		.in_ready  (core_ready),
		.in_word   (core_word),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (o_word)
	);

	assign m_axis_tdata = {4'd0, o_word.count, o_word.bytes};
	assign m_axis_tlast = o_word.last;
	assign m_axis_tuser = o_word.error;

endmodule
`default_nettype wire

// ===== src/dse_ostage.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dse_ostage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire dse_pkg::out_word_t in_word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output dse_pkg::out_word_t      out_word
);
	import dse_pkg::*;

	logic      valid_q;
	out_word_t word_q;

	// Take a new word when the slot is empty or being drained.
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= in_word;
		end
	end

endmodule
`default_nettype wire

// ===== src/dse_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dse_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      kind,
	input  wire logic [dse_pkg::IDX_W-1:0] entry_index,
	input  wire logic [63:0]               entry_data,
	input  wire logic [dse_pkg::SYM_W-1:0] symbol,
	input  wire logic [dse_pkg::CODE_W-1:0] size_code,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output dse_pkg::out_word_t             out_word
);
	import dse_pkg::*;

	state_t state_q, state_d;

	logic [63:0]        dict_mem [DICT_ENTRIES];
	logic [63:0]        dict_rdata_q;
	logic               dict_re;
	logic [DICT_AW-1:0] dict_raddr;
	logic               dict_we;

	logic [7:0]        buf_mem [BUF_DEPTH];
	logic [7:0]        buf_rdata_q;
	logic              buf_we;
	logic [BUF_AW-1:0] buf_waddr;
	logic [7:0]        buf_wdata;
	logic              buf_re;

	logic [TOT_W-1:0] total_q, total_d;
	logic [TOT_W-1:0] pos_q, pos_d;
	logic [2:0]       cnt_q, cnt_d;
	logic [2:0]       len_q, len_d;
	logic [3:0]       wcnt_q, wcnt_d;
	logic [63:0]      word_q, word_d;
	logic             rd_vld_s1;
	logic [2:0]       slot_s1;

	logic [TOT_W-1:0] add_a, sum, pos_next;
	logic [2:0]       add_b;

	logic [2:0]       code_c;
	logic [SYM_W-1:0] sym_m;
	logic [7:0]       b0;
	logic [2:0]       psl, csl;
	logic [7:0]       ofst;
	logic [12:0]      pptr;

	assign code_c = (size_code > CODE_W'(MAX_CODE)) ? CODE_W'(MAX_CODE) : size_code;
	assign sym_m  = symbol & ({SYM_W{1'b1}} >> (CODE_W'(MAX_CODE) - code_c));

	assign b0   = entry_byte(dict_rdata_q, 3'd0);
	assign psl  = b0[7:5];
	assign csl  = b0[2:0];
	assign ofst = entry_byte(dict_rdata_q, 3'd7);
	assign pptr = {b0[4:0], entry_byte(dict_rdata_q, 3'd1)};

	// Shared adder: length accumulation while walking, position advance otherwise.
	always_comb begin
		add_a = pos_q;
		add_b = 3'd1;
		if (state_q == ST_WALK) begin
			add_a = total_q;
			add_b = (psl == 3'd0) ? csl : psl;
		end
	end
	assign sum      = add_a + TOT_W'(add_b);
	assign pos_next = (sum == TOT_W'(BUF_DEPTH)) ? '0 : sum;

	assign dict_we = in_valid && in_ready && !kind;

	always_comb begin
		state_d    = state_q;
		total_d    = total_q;
		pos_d      = pos_q;
		cnt_d      = cnt_q;
		len_d      = len_q;
		wcnt_d     = wcnt_q;
		word_d     = word_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		out_word   = '0;
		dict_re    = 1'b0;
		dict_raddr = sym_m[DICT_AW-1:0];
		buf_we     = 1'b0;
		buf_waddr  = pos_q;
		buf_wdata  = entry_byte(dict_rdata_q, 3'(cnt_q + 3'd2));
		buf_re     = 1'b0;

		if (rd_vld_s1) begin
			word_d[8 * (7 - int'(slot_s1)) +: 8] = buf_rdata_q;
		end

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && kind) begin
					if (sym_m[SYM_W-1:8] == '0) begin
						buf_we    = 1'b1;
						buf_waddr = '0;
						buf_wdata = sym_m[7:0];
						total_d   = TOT_W'(1);
						pos_d     = '0;
						wcnt_d    = '0;
						word_d    = '0;
						state_d   = ST_EMIT;
					end else begin
						dict_re = 1'b1;
						total_d = '0;
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (psl == 3'd0) begin
					if (csl == 3'd0 || sum > TOT_W'(MAX_EXPANSION)) begin
						state_d = ST_ERR;
					end else begin
						total_d = sum;
						cnt_d   = '0;
						len_d   = csl;
						state_d = ST_PUTC;
					end
				end else if (psl > 3'd5 || sum > TOT_W'(MAX_EXPANSION)) begin
					state_d = ST_ERR;
				end else begin
					total_d = sum;
					pos_d   = TOT_W'(ofst);
					cnt_d   = '0;
					len_d   = psl;
					state_d = ST_PUTP;
				end
			end
			ST_PUTP: begin
				buf_we = 1'b1;
				pos_d  = pos_next;
				cnt_d  = cnt_q + 3'd1;
				if (cnt_q == len_q - 3'd1) begin
					dict_re    = 1'b1;
					dict_raddr = pptr[DICT_AW-1:0];
					state_d    = ST_WALK;
				end
			end
			ST_PUTC: begin
				buf_we    = 1'b1;
				buf_waddr = BUF_AW'(cnt_q);
				buf_wdata = entry_byte(dict_rdata_q, 3'(cnt_q + 3'd1));
				cnt_d     = cnt_q + 3'd1;
				if (cnt_q == len_q - 3'd1) begin
					pos_d   = '0;
					wcnt_d  = '0;
					word_d  = '0;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				buf_re = 1'b1;
				pos_d  = sum;
				wcnt_d = wcnt_q + 4'd1;
				if (wcnt_q == 4'd7 || sum == total_q) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				out_valid      = 1'b1;
				out_word.bytes = word_q;
				out_word.count = wcnt_q;
				out_word.last  = (pos_q == total_q);
				if (out_ready) begin
					if (pos_q == total_q) begin
						state_d = ST_IDLE;
					end else begin
						word_d  = '0;
						wcnt_d  = '0;
						state_d = ST_EMIT;
					end
				end
			end
			ST_ERR: begin
				out_valid      = 1'b1;
				out_word.last  = 1'b1;
				out_word.error = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= buf_re;
		end
	end

	always_ff @(posedge clk) begin
		total_q <= total_d;
		pos_q   <= pos_d;
		cnt_q   <= cnt_d;
		len_q   <= len_d;
		wcnt_q  <= wcnt_d;
		word_q  <= word_d;
		slot_s1 <= wcnt_q[2:0];
	end

	always_ff @(posedge clk) begin
		if (dict_we) begin
			dict_mem[entry_index[DICT_AW-1:0]] <= entry_data;
		end
		if (dict_re) begin
			dict_rdata_q <= dict_mem[dict_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[buf_waddr] <= buf_wdata;
		end
		if (buf_re) begin
			buf_rdata_q <= buf_mem[pos_q];
		end
	end

	a_walk_total: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> total_q <= TOT_W'(MAX_EXPANSION))
		else $error("running total over limit while walking");

	a_emit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> pos_q < total_q)
		else $error("emit read beyond expansion length");

	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUSH |-> (wcnt_q != 4'd0 && wcnt_q <= 4'd8))
		else $error("data word with bad byte count");

	a_land: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q) == ST_EMIT)
		else $error("buffer read landed outside emit");

endmodule
`default_nettype wire
